/* hdl/zcm_pkg.sv */
// Shared types, widths, codes and saturation helpers for the z-score covariance block.
`timescale 1ns / 1ps

package zcm_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int FC_W     = 4;
  localparam int COV_W    = 19;
  localparam int IDX_W    = 3;
  localparam int ST_W     = 2;
  localparam int Z_W      = 18;

  // Shared arithmetic widths
  localparam int DIV_W = 64;
  localparam int DSR_W = 32;
  localparam int MUL_W = 26;
  localparam int PRD_W = 2 * MUL_W;

  localparam logic [FC_W-1:0] FC_RESET = 4'd8;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FEW  = 2'd1;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd2;
  localparam logic [ST_W-1:0] ST_PART = 2'd3;

  localparam logic signed [DIV_W-1:0] Z_MAX   = 64'sd131071;
  localparam logic signed [DIV_W-1:0] Z_MIN   = -64'sd131072;
  localparam logic signed [DIV_W-1:0] COV_MAX = 64'sd262143;
  localparam logic signed [DIV_W-1:0] COV_MIN = -64'sd262144;

  // Divider request / response
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DIV_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DIV_W-1:0]  quot;
  } div_rsp_t;

  // Square root request / response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DSR_W-1:0] root;
  } sqrt_rsp_t;

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [DIV_W-1:0] v);
    logic signed [DIV_W-1:0] r;
    if (v > Z_MAX) r = Z_MAX;
    else if (v < Z_MIN) r = Z_MIN;
    else r = v;
    return r[Z_W-1:0];
  endfunction

  function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [DIV_W-1:0] v);
    logic signed [DIV_W-1:0] r;
    if (v > COV_MAX) r = COV_MAX;
    else if (v < COV_MIN) r = COV_MIN;
    else r = v;
    return r[COV_W-1:0];
  endfunction

endpackage

/* hdl/zcm_if.sv */
// Channel interfaces: sample input, covariance output and feature count write.
`timescale 1ns / 1ps

interface zcm_in_if;
  import zcm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       end_of_set;
  modport source (output valid, sample_value, end_of_set, input ready);
  modport sink   (input valid, sample_value, end_of_set, output ready);
endinterface

interface zcm_out_if;
  import zcm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [COV_W-1:0] cov_value;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic                    zero_variance;
  logic [ST_W-1:0]         status;
  logic                    last_result;
  modport source (output valid, cov_value, row_index, col_index, zero_variance, status,
                  last_result, input ready);
  modport sink   (input valid, cov_value, row_index, col_index, zero_variance, status,
                  last_result, output ready);
endinterface

interface zcm_cfg_if;
  import zcm_pkg::*;
  logic            valid;
  logic            ready;
  logic [FC_W-1:0] feature_count;
  modport source (output valid, feature_count, input ready);
  modport sink   (input valid, feature_count, output ready);
endinterface

/* hdl/zcm_div.sv */
// Iterative restoring divider, one quotient bit per cycle, sign applied at the end.
`timescale 1ns / 1ps

module zcm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  zcm_pkg::div_req_t req_i,
  output zcm_pkg::div_rsp_t rsp_o
);
  import zcm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic                    busy_q, done_q, neg_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [DIV_W-1:0]        dvd_q;
  logic [DSR_W-1:0]        rem_q, dsr_q;
  logic signed [DIV_W-1:0] quot_q;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W+1:0] diff;
  logic             ge;
  logic [DSR_W-1:0] rem_nx;
  logic [DIV_W-1:0] dvd_nx;

  // One restoring step
  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
    ge     = ~diff[DSR_W+1];
    rem_nx = ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    dvd_nx = {dvd_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        neg_q  <= req_i.neg;
        cnt_q  <= '0;
        dvd_q  <= req_i.dividend;
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
      end else if (busy_q) begin
        dvd_q <= dvd_nx;
        rem_q <= rem_nx;
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quot_q <= neg_q ? -$signed(dvd_nx) : $signed(dvd_nx);
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* hdl/zcm_sqrt.sv */
// Iterative floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module zcm_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  zcm_pkg::sqrt_req_t req_i,
  output zcm_pkg::sqrt_rsp_t rsp_o
);
  import zcm_pkg::*;

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] v_q, r_q, b_q;
  logic [DSR_W-1:0] root_q;

  logic [DIV_W-1:0] t, v_nx, r_nx;
  logic             ge;

  // One digit step
  always_comb begin
    t    = r_q + b_q;
    ge   = (v_q >= t);
    v_nx = ge ? (v_q - t) : v_q;
    r_nx = ge ? ((r_q >> 1) + b_q) : (r_q >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      v_q    <= '0;
      r_q    <= '0;
      b_q    <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        v_q    <= req_i.value;
        r_q    <= '0;
        b_q    <= {2'b01, {(DIV_W-2){1'b0}}};
      end else if (busy_q) begin
        v_q   <= v_nx;
        r_q   <= r_nx;
        b_q   <= b_q >> 2;
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          root_q <= r_nx[DSR_W-1:0];
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

/* hdl/zscore_covariance_matrix.sv */
// Top level: sample store, z-score store, sequencer, shared multiplier, divider and root.
//
// Usage
//   in_if  : one signed sample per item, row-major, F = feature_count values per row.
//            The item with end_of_set closes the set. Loading takes one item per cycle.
//   out_if : after the set closes, F*F covariance items, row-major, last_result on
//            the final one. Each carries status and the zero-variance flag.
//   cfg_if : feature_count write, always ready; write only while the block is idle.
// Work per set (N rows, F features)
//   Per feature: a pass of sums over the N rows, two divides and a root, and,
//   if the root is nonzero, one divide per row for the z-scores.
//   Per entry: N multiply-accumulate steps plus a divide.
//   All divides go through the one shared restoring divider, one at a time.
// Reset: feature count returns to 8, the row and column counters clear; the
//   stores hold no valid data and need no clearing pass.
// Stall: a result waits in the output register while ready is low; input is not
//   accepted until the last result of the set has been taken.
`timescale 1ns / 1ps

module zscore_covariance_matrix #(
  parameter int MAX_SAMPLES  = 256,
  parameter int MAX_FEATURES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  zcm_in_if.sink    in_if,
  zcm_out_if.source out_if,
  zcm_cfg_if.sink   cfg_if
);
  import zcm_pkg::*;

  localparam int CW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int RAW   = $clog2(MAX_SAMPLES);
  localparam int RW    = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = RAW + CW;
  localparam int DEPTH = MAX_SAMPLES * (2 ** CW);
  localparam int SUM_W = SAMPLE_W + RW + 1;

  // Sequencer states
  localparam logic [4:0] S_LOAD    = 5'd0;
  localparam logic [4:0] S_SUM_RD  = 5'd1;
  localparam logic [4:0] S_SUM_ACC = 5'd2;
  localparam logic [4:0] S_MEAN    = 5'd3;
  localparam logic [4:0] S_SS_RD   = 5'd4;
  localparam logic [4:0] S_SS_D    = 5'd5;
  localparam logic [4:0] S_SS_MUL  = 5'd6;
  localparam logic [4:0] S_SS_ACC  = 5'd7;
  localparam logic [4:0] S_VAR     = 5'd8;
  localparam logic [4:0] S_SQRT    = 5'd9;
  localparam logic [4:0] S_Z_RD    = 5'd10;
  localparam logic [4:0] S_Z_D     = 5'd11;
  localparam logic [4:0] S_Z_DIV   = 5'd12;
  localparam logic [4:0] S_PAIR    = 5'd13;
  localparam logic [4:0] S_MAC_A   = 5'd14;
  localparam logic [4:0] S_MAC_B   = 5'd15;
  localparam logic [4:0] S_MAC_C   = 5'd16;
  localparam logic [4:0] S_MAC_D   = 5'd17;
  localparam logic [4:0] S_COV     = 5'd18;
  localparam logic [4:0] S_EMIT    = 5'd19;

  logic [4:0]              state_q;
  logic [FC_W-1:0]         fc_q, nf_q, nf;
  logic [CW-1:0]           col_q, f_q, i_q, j_q;
  logic [RW-1:0]           rows_q, n_q;
  logic [RAW-1:0]          k_q;
  logic                    ovf_q;
  logic [ST_W-1:0]         status_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [DIV_W-1:0]        ss_q;
  logic signed [DIV_W-1:0] acc_q;
  logic signed [MUL_W-1:0] mean_q, d_q;
  logic [DSR_W-1:0]        std_q;
  logic [MAX_FEATURES-1:0] zvar_q;
  logic signed [Z_W-1:0]   zi_q;
  logic signed [COV_W-1:0] cov_q;
  logic                    zvo_q;

  div_req_t  div_req_q;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req_q;
  sqrt_rsp_t sqrt_rsp;

  // Active feature count
  always_comb begin
    if (fc_q == '0) nf = FC_W'(1);
    else if (fc_q > FC_W'(MAX_FEATURES)) nf = FC_W'(MAX_FEATURES);
    else nf = fc_q;
  end

  // Load bookkeeping for the accepted item
  logic            in_acc, room, row_done, ovf_nx;
  logic [CW-1:0]   col_nx;
  logic [RW-1:0]   rows_nx;
  logic [ST_W-1:0] status_nx;

  assign in_acc   = in_if.valid && in_if.ready;
  assign room     = rows_q < RW'(MAX_SAMPLES);
  assign row_done = (FC_W'(col_q) + FC_W'(1)) >= nf;

  always_comb begin
    col_nx  = col_q;
    rows_nx = rows_q;
    ovf_nx  = ovf_q;
    if (room) begin
      if (row_done) begin
        col_nx  = '0;
        rows_nx = rows_q + RW'(1);
      end else begin
        col_nx = col_q + CW'(1);
      end
    end else begin
      ovf_nx = 1'b1;
    end
    if (rows_nx < RW'(2)) status_nx = ST_FEW;
    else if (ovf_nx) status_nx = ST_OVF;
    else if (col_nx != '0) status_nx = ST_PART;
    else status_nx = ST_OK;
  end

  // Sample store
  logic signed [SAMPLE_W-1:0] smem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic [AW-1:0]              st_waddr, st_raddr;

  assign st_waddr = {rows_q[RAW-1:0], col_q};
  assign st_raddr = {k_q, f_q};

  always_ff @(posedge clk_i) begin
    if (in_acc && room) smem[st_waddr] <= in_if.sample_value;
    rd_q <= smem[st_raddr];
  end

  // Z-score store
  logic signed [Z_W-1:0] zmem [DEPTH];
  logic signed [Z_W-1:0] zr_q;
  logic [AW-1:0]         z_raddr;
  logic                  z_we;

  assign z_we    = (state_q == S_Z_DIV) && div_rsp.done;
  assign z_raddr = {k_q, (state_q == S_MAC_B) ? j_q : i_q};

  always_ff @(posedge clk_i) begin
    if (z_we) zmem[st_raddr] <= sat_z(div_rsp.quot);
    zr_q <= zmem[z_raddr];
  end

  // Centred value from the store read
  logic signed [MUL_W-1:0] d_c, d_abs;
  assign d_c   = ($signed(MUL_W'(rd_q)) <<< 8) - mean_q;
  assign d_abs = d_c[MUL_W-1] ? -d_c : d_c;

  // Shared multiplier, registered
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PRD_W-1:0] p_q;
  assign mul_a = (state_q == S_MAC_C) ? MUL_W'(zi_q) : d_q;
  assign mul_b = (state_q == S_MAC_C) ? MUL_W'(zr_q) : d_q;

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  // Loop ends
  logic k_last, f_last, i_last, j_last;
  logic [SUM_W-1:0]        sum_abs;
  logic [DIV_W-1:0]        acc_abs;
  logic signed [SUM_W-1:0] sum_nx;
  logic signed [DIV_W-1:0] acc_nx;

  assign k_last  = (RW'(k_q) + RW'(1)) == n_q;
  assign f_last  = (FC_W'(f_q) + FC_W'(1)) == nf_q;
  assign i_last  = (FC_W'(i_q) + FC_W'(1)) == nf_q;
  assign j_last  = (FC_W'(j_q) + FC_W'(1)) == nf_q;
  assign sum_nx  = sum_q + SUM_W'(rd_q);
  assign sum_abs = sum_nx[SUM_W-1] ? $unsigned(-sum_nx) : $unsigned(sum_nx);
  assign acc_nx  = acc_q + DIV_W'(p_q);
  assign acc_abs = acc_nx[DIV_W-1] ? $unsigned(-acc_nx) : $unsigned(acc_nx);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      fc_q       <= FC_RESET;
      nf_q       <= FC_RESET;
      col_q      <= '0;
      rows_q     <= '0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      status_q   <= ST_OK;
      f_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      sum_q      <= '0;
      ss_q       <= '0;
      acc_q      <= '0;
      mean_q     <= '0;
      d_q        <= '0;
      std_q      <= '0;
      zvar_q     <= '0;
      zi_q       <= '0;
      cov_q      <= '0;
      zvo_q      <= 1'b0;
      div_req_q  <= '0;
      sqrt_req_q <= '0;
    end else begin
      div_req_q.start  <= 1'b0;
      sqrt_req_q.start <= 1'b0;
      if (cfg_if.valid) fc_q <= cfg_if.feature_count;

      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            col_q  <= col_nx;
            rows_q <= rows_nx;
            ovf_q  <= ovf_nx;
            if (in_if.end_of_set) begin
              col_q    <= '0;
              rows_q   <= '0;
              ovf_q    <= 1'b0;
              n_q      <= rows_nx;
              status_q <= status_nx;
              nf_q     <= nf;
              f_q      <= '0;
              i_q      <= '0;
              j_q      <= '0;
              k_q      <= '0;
              sum_q    <= '0;
              state_q  <= (rows_nx < RW'(2)) ? S_PAIR : S_SUM_RD;
            end
          end
        end
        // Mean
        S_SUM_RD: state_q <= S_SUM_ACC;
        S_SUM_ACC: begin
          sum_q <= sum_nx;
          if (k_last) begin
            div_req_q <= '{start: 1'b1, neg: sum_nx[SUM_W-1],
                           dividend: DIV_W'(sum_abs) << 8, divisor: DSR_W'(n_q)};
            state_q   <= S_MEAN;
          end else begin
            k_q     <= k_q + RAW'(1);
            state_q <= S_SUM_RD;
          end
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            mean_q  <= div_rsp.quot[MUL_W-1:0];
            k_q     <= '0;
            ss_q    <= '0;
            state_q <= S_SS_RD;
          end
        end
        // Sum of squared deviations
        S_SS_RD: state_q <= S_SS_D;
        S_SS_D: begin
          d_q     <= d_c;
          state_q <= S_SS_MUL;
        end
        S_SS_MUL: state_q <= S_SS_ACC;
        S_SS_ACC: begin
          if (k_last) begin
            div_req_q <= '{start: 1'b1, neg: 1'b0,
                           dividend: ss_q + DIV_W'(p_q), divisor: DSR_W'(n_q)};
            state_q   <= S_VAR;
          end else begin
            ss_q    <= ss_q + DIV_W'(p_q);
            k_q     <= k_q + RAW'(1);
            state_q <= S_SS_RD;
          end
        end
        S_VAR: begin
          if (div_rsp.done) begin
            sqrt_req_q <= '{start: 1'b1, value: $unsigned(div_rsp.quot)};
            state_q    <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_rsp.done) begin
            std_q       <= sqrt_rsp.root;
            zvar_q[f_q] <= (sqrt_rsp.root == '0);
            k_q         <= '0;
            if (sqrt_rsp.root != '0) begin
              state_q <= S_Z_RD;
            end else if (f_last) begin
              state_q <= S_PAIR;
            end else begin
              f_q     <= f_q + CW'(1);
              sum_q   <= '0;
              state_q <= S_SUM_RD;
            end
          end
        end
        // Z-scores of this feature
        S_Z_RD: state_q <= S_Z_D;
        S_Z_D: begin
          div_req_q <= '{start: 1'b1, neg: d_c[MUL_W-1],
                         dividend: DIV_W'($unsigned(d_abs)) << 12, divisor: std_q};
          state_q   <= S_Z_DIV;
        end
        S_Z_DIV: begin
          if (div_rsp.done) begin
            if (!k_last) begin
              k_q     <= k_q + RAW'(1);
              state_q <= S_Z_RD;
            end else if (f_last) begin
              state_q <= S_PAIR;
            end else begin
              f_q     <= f_q + CW'(1);
              k_q     <= '0;
              sum_q   <= '0;
              state_q <= S_SUM_RD;
            end
          end
        end
        // One covariance entry
        S_PAIR: begin
          if (n_q < RW'(2)) begin
            cov_q   <= '0;
            zvo_q   <= 1'b0;
            state_q <= S_EMIT;
          end else if (zvar_q[i_q] || zvar_q[j_q]) begin
            cov_q   <= '0;
            zvo_q   <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            acc_q   <= '0;
            k_q     <= '0;
            state_q <= S_MAC_A;
          end
        end
        S_MAC_A: state_q <= S_MAC_B;
        S_MAC_B: begin
          zi_q    <= zr_q;
          state_q <= S_MAC_C;
        end
        S_MAC_C: state_q <= S_MAC_D;
        S_MAC_D: begin
          acc_q <= acc_nx;
          if (k_last) begin
            div_req_q <= '{start: 1'b1, neg: acc_nx[DIV_W-1], dividend: acc_abs,
                           divisor: DSR_W'({n_q - RW'(1), 8'd0})};
            state_q   <= S_COV;
          end else begin
            k_q     <= k_q + RAW'(1);
            state_q <= S_MAC_A;
          end
        end
        S_COV: begin
          if (div_rsp.done) begin
            cov_q   <= sat_cov(div_rsp.quot);
            zvo_q   <= 1'b0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_if.ready) begin
            if (!j_last) begin
              j_q     <= j_q + CW'(1);
              state_q <= S_PAIR;
            end else if (!i_last) begin
              i_q     <= i_q + CW'(1);
              j_q     <= '0;
              state_q <= S_PAIR;
            end else begin
              state_q <= S_LOAD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Shared units
  zcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  zcm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req_q),
    .rsp_o  (sqrt_rsp)
  );

  // Channel outputs
  assign in_if.ready          = (state_q == S_LOAD);
  assign cfg_if.ready         = 1'b1;
  assign out_if.valid         = (state_q == S_EMIT);
  assign out_if.cov_value     = cov_q;
  assign out_if.row_index     = IDX_W'(i_q);
  assign out_if.col_index     = IDX_W'(j_q);
  assign out_if.zero_variance = zvo_q;
  assign out_if.status        = status_q;
  assign out_if.last_result   = i_last && j_last;

`ifndef SYNTHESIS
  ap_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  ap_eos_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.end_of_set) |=> !in_if.ready)
    else $error("input taken after end of set");

  ap_last_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && out_if.last_result) |=> in_if.ready)
    else $error("not back to loading after last result");

  ap_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (FC_W'(out_if.row_index) < nf_q && FC_W'(out_if.col_index) < nf_q))
    else $error("entry index beyond feature count");
`endif

endmodule
